// File: hw/rtl/i2c_master_bit_sequencer_core_assert.svh
// Assertion macros used by the I2C bit sequencer checker.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cbs check failed");

// Consequent must hold in the cycle after the antecedent.
`define I2CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cbs check failed");

`endif

// File: hw/rtl/i2cbs_pkg.sv
// Types, constants and sequence tables of the I2C master bit sequencer.
package i2cbs_pkg;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_SEND_ACK = 3'd5,
        CMD_READ_ACK = 3'd6
    } t_cmd;

    localparam logic [15:0] TICKS_RESET     = 16'd10;
    localparam int          QUEUE_DEPTH_DEF = 4;
    localparam logic        REG_TPP_SEL     = 1'b0;

    // Classified item as held in the queue
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] load_byte;
        logic       sda;
    } t_item;

    // Queue write side
    typedef struct packed {
        logic  push;
        t_item item;
    } t_qwr;

    // Queue read side
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qrd;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack;
        logic       rejected;
    } t_result;

    function automatic logic [4:0] seq_len(input t_cmd cmd);
        logic [4:0] len;
        unique case (cmd)
            CMD_START:    len = 5'd4;
            CMD_STOP:     len = 5'd3;
            CMD_WRITE:    len = 5'd24;
            CMD_READ:     len = 5'd25;
            CMD_SEND_ACK: len = 5'd3;
            CMD_READ_ACK: len = 5'd4;
            default:      len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/i2cbs_front.sv
// Input stage: takes items, folds unused codes into ticks and picks the shifter load.
module i2cbs_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_cmd,
    input  logic [7:0]        i_write_data,
    input  logic              i_ack_value,
    input  logic              i_sda_sample,
    input  logic              i_full,
    output i2cbs_pkg::t_qwr   o_wr
);
    import i2cbs_pkg::*;

    t_cmd w_cmd;

    always_comb begin
        unique case (i_cmd)
            CMD_START:    w_cmd = CMD_START;
            CMD_STOP:     w_cmd = CMD_STOP;
            CMD_WRITE:    w_cmd = CMD_WRITE;
            CMD_READ:     w_cmd = CMD_READ;
            CMD_SEND_ACK: w_cmd = CMD_SEND_ACK;
            CMD_READ_ACK: w_cmd = CMD_READ_ACK;
            default:      w_cmd = CMD_TICK;
        endcase
    end

    assign o_in_ready = !i_full;

    always_comb begin
        o_wr.push          = i_in_valid && !i_full;
        o_wr.item.cmd      = w_cmd;
        o_wr.item.sda      = i_sda_sample;
        unique case (w_cmd)
            CMD_WRITE:    o_wr.item.load_byte = i_write_data;
            CMD_SEND_ACK: o_wr.item.load_byte = {7'd0, i_ack_value};
            default:      o_wr.item.load_byte = 8'd0;
        endcase
    end

endmodule

// File: hw/rtl/i2cbs_queue.sv
// Short queue between the input stage and the sequencer.
module i2cbs_queue #(
    parameter int DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  i2cbs_pkg::t_qwr  i_wr,
    output logic             o_full,
    output i2cbs_pkg::t_qrd  o_rd,
    input  logic             i_pop
);
    import i2cbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full     = (r_count == FULL);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.item  = r_mem[r_rd_ptr];
    assign w_push     = i_wr.push && !o_full;
    assign w_pop      = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/i2cbs_back.sv
// Sequencer: runs the phase lists on the line levels and registers one result per item.
module i2cbs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_ticks_per_phase,
    input  i2cbs_pkg::t_qrd    i_rd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output i2cbs_pkg::t_result o_result
);
    import i2cbs_pkg::*;

    t_cmd        r_active, n_active;
    logic [4:0]  r_phase,  n_phase;
    logic [1:0]  r_sub,    n_sub;
    logic [2:0]  r_bit,    n_bit;
    logic [15:0] r_tick,   n_tick;
    logic [7:0]  r_shift,  n_shift;
    logic        r_scl,    n_scl;
    logic        r_sda,    n_sda;
    logic [7:0]  r_rx,     n_rx;
    logic        r_ack,    n_ack;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_res;
    logic        w_fire;
    logic [15:0] w_limit;

    assign w_fire      = i_rd.valid && (!r_out_valid || i_out_ready);
    assign o_pop       = w_fire;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign w_limit     = (i_ticks_per_phase == 16'd0) ? 16'd1 : i_ticks_per_phase;

    always_comb begin
        logic [15:0] tick_inc;
        logic        apply;
        logic        done;
        logic        rej;
        n_active = r_active;
        n_phase  = r_phase;
        n_sub    = r_sub;
        n_bit    = r_bit;
        n_tick   = r_tick;
        n_shift  = r_shift;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_rx     = r_rx;
        n_ack    = r_ack;
        tick_inc = r_tick + 16'd1;
        apply    = 1'b0;
        done     = 1'b0;
        rej      = 1'b0;

        if (w_fire) begin
            if (i_rd.item.cmd != CMD_TICK) begin
                if (r_active != CMD_TICK) begin
                    rej = 1'b1;
                end else begin
                    n_active = i_rd.item.cmd;
                    n_phase  = 5'd0;
                    n_sub    = 2'd0;
                    n_bit    = 3'd0;
                    n_tick   = 16'd0;
                    n_shift  = i_rd.item.load_byte;
                    apply    = 1'b1;
                end
            end else if (r_active != CMD_TICK) begin
                if (tick_inc >= w_limit) begin
                    n_tick  = 16'd0;
                    n_phase = r_phase + 5'd1;
                    // Bit/sub-phase counters; the read lead-in phase does not step them
                    if (!(r_active == CMD_READ && r_phase == 5'd0)) begin
                        if (r_sub == 2'd2) begin
                            n_sub = 2'd0;
                            n_bit = r_bit + 3'd1;
                        end else begin
                            n_sub = r_sub + 2'd1;
                        end
                    end
                    if (n_phase >= seq_len(r_active)) begin
                        if (r_active == CMD_READ) begin
                            n_rx = r_shift;
                        end else if (r_active == CMD_READ_ACK) begin
                            n_ack = r_shift[0];
                        end
                        n_active = CMD_TICK;
                        n_phase  = 5'd0;
                        done     = 1'b1;
                    end else begin
                        apply = 1'b1;
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
        end

        if (apply) begin
            unique case (n_active)
                CMD_START: begin
                    priority if (n_phase == 5'd0) n_sda = 1'b1;
                    else if (n_phase == 5'd1)     n_scl = 1'b1;
                    else if (n_phase == 5'd2)     n_sda = 1'b0;
                    else                          n_scl = 1'b0;
                end
                CMD_STOP: begin
                    priority if (n_phase == 5'd0) n_sda = 1'b0;
                    else if (n_phase == 5'd1)     n_scl = 1'b1;
                    else                          n_sda = 1'b1;
                end
                CMD_WRITE: begin
                    priority if (n_sub == 2'd0) n_sda = n_shift[3'd7 - n_bit];
                    else if (n_sub == 2'd1)     n_scl = 1'b1;
                    else                        n_scl = 1'b0;
                end
                CMD_READ: begin
                    priority if (n_phase == 5'd0) n_sda = 1'b1;
                    else if (n_sub == 2'd0)       n_scl = 1'b1;
                    else if (n_sub == 2'd1) begin
                        if (i_rd.item.sda) begin
                            n_shift[3'd7 - n_bit] = 1'b1;
                        end
                    end else                      n_scl = 1'b0;
                end
                CMD_SEND_ACK: begin
                    priority if (n_phase == 5'd0) n_sda = n_shift[0];
                    else if (n_phase == 5'd1)     n_scl = 1'b1;
                    else                          n_scl = 1'b0;
                end
                CMD_READ_ACK: begin
                    priority if (n_phase == 5'd0) n_sda = 1'b1;
                    else if (n_phase == 5'd1)     n_scl = 1'b1;
                    else if (n_phase == 5'd2)     n_shift[0] = i_rd.item.sda;
                    else                          n_scl = 1'b0;
                end
                default: begin
                end
            endcase
        end

        w_res.scl      = n_scl;
        w_res.sda      = n_sda;
        w_res.busy     = (n_active != CMD_TICK);
        w_res.done     = done;
        w_res.rx_byte  = n_rx;
        w_res.ack      = n_ack;
        w_res.rejected = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CMD_TICK;
            r_phase     <= 5'd0;
            r_sub       <= 2'd0;
            r_bit       <= 3'd0;
            r_tick      <= 16'd0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= 8'd0;
            r_ack       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_phase  <= n_phase;
            r_sub    <= n_sub;
            r_bit    <= n_bit;
            r_tick   <= n_tick;
            r_shift  <= n_shift;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_rx     <= n_rx;
            r_ack    <= n_ack;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result while the far side stalls
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

endmodule

// File: hw/rtl/i2c_master_bit_sequencer_core.sv
// I2C master bit sequencer. Each input item is a command or a time tick carrying the
// sampled SDA level; each produces exactly one result with the SCL/SDA drives, busy,
// done, the last read byte, the last read acknowledge and a rejected flag. The block
// takes one item per clock and returns one result per clock when the output is not
// stalled: the sequencer handles each item as it is popped, and an item passes through
// the input queue and then the result register on its way to the result. The input
// queue of QUEUE_DEPTH entries absorbs output stalls.
// ticks_per_phase sits at byte address 0 of the register port; 0 behaves as 1.
module i2c_master_bit_sequencer_core #(
    parameter int QUEUE_DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_write_data,
    input  logic        i_ack_value,
    input  logic        i_sda_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_ack_received,
    output logic        o_rejected
);
    import i2cbs_pkg::*;

    logic [15:0] r_tpp;
    t_qwr        w_wr;
    t_qrd        w_rd;
    logic        w_full;
    logic        w_pop;
    t_result     w_res;

    assign o_pready = 1'b1;
    assign o_prdata = (i_psel && !i_pwrite && (i_paddr[2] == REG_TPP_SEL)) ?
                      {16'd0, r_tpp} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpp <= TICKS_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_TPP_SEL)) begin
            r_tpp <= i_pwdata[15:0];
        end
    end

    i2cbs_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_write_data (i_write_data),
        .i_ack_value  (i_ack_value),
        .i_sda_sample (i_sda_sample),
        .i_full       (w_full),
        .o_wr         (w_wr)
    );

    i2cbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_full  (w_full),
        .o_rd    (w_rd),
        .i_pop   (w_pop)
    );

    i2cbs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ticks_per_phase (r_tpp),
        .i_rd              (w_rd),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result          (w_res)
    );

    assign o_scl_out      = w_res.scl;
    assign o_sda_out      = w_res.sda;
    assign o_busy_res     = w_res.busy;
    assign o_done_res     = w_res.done;
    assign o_read_data    = w_res.rx_byte;
    assign o_ack_received = w_res.ack;
    assign o_rejected     = w_res.rejected;

endmodule

// File: hw/rtl/i2cbs_checker.sv
// Port-level checks of the I2C bit sequencer, bound to the top level.
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2cbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_scl_out,
    input logic       i_sda_out,
    input logic       i_busy_res,
    input logic       i_done_res,
    input logic [7:0] i_read_data,
    input logic       i_rejected
);

    // A stalled result holds
    `I2CBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_scl_out) && $stable(i_sda_out)
        && $stable(i_read_data) && $stable(i_rejected))

    // A finished sequence leaves the engine idle
    `I2CBS_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, i_out_valid && i_done_res, !i_busy_res)

    // A refused command leaves the running sequence busy
    `I2CBS_ASSERT_SAME(a_rej_busy, i_clk, i_rst_n, i_out_valid && i_rejected, i_busy_res)

    // Completion comes on ticks only, refusal on commands only
    `I2CBS_ASSERT_SAME(a_done_rej, i_clk, i_rst_n, i_out_valid, !(i_done_res && i_rejected))

endmodule

bind i2c_master_bit_sequencer_core i2cbs_checker u_i2cbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_scl_out   (o_scl_out),
    .i_sda_out   (o_sda_out),
    .i_busy_res  (o_busy_res),
    .i_done_res  (o_done_res),
    .i_read_data (o_read_data),
    .i_rejected  (o_rejected)
);
